### rtl/core/gn3_pkg.sv
// ----------------------------------------------------------------------------
// gn3_pkg: shared constants for the 3D gradient noise block
// Item modes, permutation axes, fixed field widths and parameter defaults.
// ----------------------------------------------------------------------------
package gn3_pkg;

  localparam int TABLE_SIZE_DEF = 256;
  localparam int FRAC_BITS_DEF  = 16;

  localparam int COORD_W = 32;
  localparam int PERM_W  = 8;
  localparam int GRAD_W  = 16;
  localparam int NOISE_W = 16;

  localparam logic [1:0] MODE_EVAL = 2'd0;
  localparam logic [1:0] MODE_PERM = 2'd1;
  localparam logic [1:0] MODE_GRAD = 2'd2;

  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

endpackage

### rtl/core/gn3_ram.sv
// ----------------------------------------------------------------------------
// gn3_ram: generic table memory
// One write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module gn3_ram
  import gn3_pkg::*;
#(
  parameter int Width = 8,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_a_i,
  input  logic [$clog2(Depth)-1:0] raddr_b_i,
  output logic [Width-1:0]         rdata_a_o,
  output logic [Width-1:0]         rdata_b_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_a_q;
  logic [Width-1:0] rdata_b_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_a_q <= mem[raddr_a_i];
      rdata_b_q <= mem[raddr_b_i];
    end
  end

  assign rdata_a_o = rdata_a_q;
  assign rdata_b_o = rdata_b_q;

endmodule

### rtl/core/gradient_noise_3d_top.sv
// ----------------------------------------------------------------------------
// gradient_noise_3d_top: pipelined 3D gradient noise evaluator
// Eight-stage pipeline, per-axis permutation RAMs, replicated gradient RAM.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries one beat per item. Mode
//   evaluate takes a Q16.16 point and yields one noise beat; modes load
//   permutation and load gradient write one table entry and yield nothing.
//   Output channel (out_valid_o / out_stall_i) carries noise_value_o, Q1.14
//   saturated.
//   Throughput: one item per cycle unless the output stalls. Every stage is a
//   register, so a beat can enter each cycle while earlier beats are still in
//   flight. A noise beat passes through every stage register to the output.
//   The rate is set by the corner reads: each permutation table is a
//   dual-read RAM (lower and upper cell), and the gradient table is held in
//   four dual-read copies so all eight corners read in the same cycle.
//   Loads travel down the pipe and write at the stage where that table is
//   read, so every item sees exactly the loads accepted before it.
//   Reset clears the valid bits only; table contents stay undefined until
//   loaded. When the receiver stalls a valid output, the whole pipe holds
//   and in_stall_o rises; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module gradient_noise_3d_top
  import gn3_pkg::*;
#(
  parameter int TableSize = TABLE_SIZE_DEF,
  parameter int FracBits  = FRAC_BITS_DEF
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [1:0]                mode_i,
  input  logic signed [COORD_W-1:0] coord_x_i,
  input  logic signed [COORD_W-1:0] coord_y_i,
  input  logic signed [COORD_W-1:0] coord_z_i,
  input  logic [PERM_W-1:0]         table_index_i,
  input  logic [1:0]                perm_axis_i,
  input  logic [PERM_W-1:0]         perm_value_i,
  input  logic signed [GRAD_W-1:0]  grad_x_i,
  input  logic signed [GRAD_W-1:0]  grad_y_i,
  input  logic signed [GRAD_W-1:0]  grad_z_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [NOISE_W-1:0] noise_value_o
);

  localparam int F     = FracBits;
  localparam int IdxW  = $clog2(TableSize);
  localparam int GW3   = 3 * GRAD_W;
  localparam int PrW   = GRAD_W + F + 1;   // gradient times offset
  localparam int SumW  = PrW + 2;          // three products summed
  localparam int DW    = GRAD_W + 3;       // dot product, Q1.14 range
  localparam int TW    = DW + 2;           // weighted term
  localparam int HW    = TW + 2;           // sum of four terms
  localparam int AccW  = TW + 3;           // sum of eight terms

  localparam logic [F:0]   One   = {1'b1, {F{1'b0}}};
  localparam logic [F+1:0] Three = {2'b11, {F{1'b0}}};
  localparam logic signed [AccW-1:0] SatHi = AccW'(32767);
  localparam logic signed [AccW-1:0] SatLo = -AccW'(32768);

  // Whole pipe advances unless the output beat is stalled.
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // --------------------------------------------------------------------------
  // Stage 1: cell index and fraction per axis, load fields
  // --------------------------------------------------------------------------
  logic                 v1_q;
  logic [1:0]           mode1_q;
  logic [IdxW-1:0]      ix1_q   [3];
  logic [F-1:0]         frac1_q [3];
  logic [IdxW-1:0]      tidx1_q;
  logic [1:0]           axis1_q;
  logic [PERM_W-1:0]    pval1_q;
  logic [GW3-1:0]       grad1_q;

  logic signed [COORD_W-1:0] coord  [3];
  logic signed [COORD_W-1:0] cshift [3];

  always_comb begin
    coord[0] = coord_x_i;
    coord[1] = coord_y_i;
    coord[2] = coord_z_i;
    for (int a = 0; a < 3; a++) begin
      cshift[a] = coord[a] >>> F;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode1_q <= mode_i;
      for (int a = 0; a < 3; a++) begin
        ix1_q[a]   <= cshift[a][IdxW-1:0];
        frac1_q[a] <= coord[a][F-1:0];
      end
      tidx1_q <= IdxW'(table_index_i);
      axis1_q <= perm_axis_i;
      pval1_q <= perm_value_i;
      grad1_q <= {grad_z_i, grad_y_i, grad_x_i};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 -> 2: permutation reads and loads, u*u
  // --------------------------------------------------------------------------
  logic [PERM_W-1:0] plo [3];
  logic [PERM_W-1:0] phi [3];
  logic [1:0]        axis_code [3];

  assign axis_code[0] = AXIS_X;
  assign axis_code[1] = AXIS_Y;
  assign axis_code[2] = AXIS_Z;

  for (genvar a = 0; a < 3; a++) begin : g_perm
    logic [IdxW-1:0] ix_up;
    assign ix_up = ix1_q[a] + IdxW'(1);
    gn3_ram #(
      .Width (PERM_W),
      .Depth (TableSize)
    ) u_perm (
      .clk_i     (clk_i),
      .we_i      (adv && v1_q && (mode1_q == MODE_PERM) && (axis1_q == axis_code[a])),
      .waddr_i   (tidx1_q),
      .wdata_i   (pval1_q),
      .re_i      (adv),
      .raddr_a_i (ix1_q[a]),
      .raddr_b_i (ix_up),
      .rdata_a_o (plo[a]),
      .rdata_b_o (phi[a])
    );
  end

  logic            v2_q;
  logic [1:0]      mode2_q;
  logic [F-1:0]    frac2_q [3];
  logic [F-1:0]    usq2_q  [3];
  logic [IdxW-1:0] tidx2_q;
  logic [GW3-1:0]  grad2_q;
  logic [2*F-1:0]  usq     [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      usq[a] = frac1_q[a] * frac1_q[a];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      mode2_q <= mode1_q;
      for (int a = 0; a < 3; a++) begin
        frac2_q[a] <= frac1_q[a];
        usq2_q[a]  <= usq[a][2*F-1:F];
      end
      tidx2_q <= tidx1_q;
      grad2_q <= grad1_q;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2 -> 3: corner hashes, gradient reads and loads, smoothstep
  // --------------------------------------------------------------------------
  logic [IdxW-1:0] ghash [8];
  logic [GW3-1:0]  gdat  [8];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      ghash[c] = IdxW'((c[2] ? phi[0] : plo[0]) ^
                       (c[1] ? phi[1] : plo[1]) ^
                       (c[0] ? phi[2] : plo[2]));
    end
  end

  for (genvar k = 0; k < 4; k++) begin : g_grad
    gn3_ram #(
      .Width (GW3),
      .Depth (TableSize)
    ) u_grad (
      .clk_i     (clk_i),
      .we_i      (adv && v2_q && (mode2_q == MODE_GRAD)),
      .waddr_i   (tidx2_q),
      .wdata_i   (grad2_q),
      .re_i      (adv),
      .raddr_a_i (ghash[2*k]),
      .raddr_b_i (ghash[2*k+1]),
      .rdata_a_o (gdat[2*k]),
      .rdata_b_o (gdat[2*k+1])
    );
  end

  logic [F+1:0]   kfac [3];
  logic [2*F+1:0] sprod [3];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      kfac[a]  = Three - {1'b0, frac2_q[a], 1'b0};
      sprod[a] = usq2_q[a] * kfac[a];
    end
  end

  logic         v3_q;
  logic [F-1:0] frac3_q [3];
  logic [F:0]   sm3_q   [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q && (mode2_q == MODE_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int a = 0; a < 3; a++) begin
        frac3_q[a] <= frac2_q[a];
        sm3_q[a]   <= sprod[a][2*F:F];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 3 -> 4: gradient times offset, xy weights
  // --------------------------------------------------------------------------
  logic signed [F:0]   offs [3][2];
  logic [F:0]          wgt  [3][2];
  logic signed [PrW-1:0] prod [8][3];
  logic [2*F+1:0]      wxy  [4];

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      offs[a][0] = $signed({1'b0, frac3_q[a]});
      offs[a][1] = $signed({1'b0, frac3_q[a]} - One);
      wgt[a][0]  = One - sm3_q[a];
      wgt[a][1]  = sm3_q[a];
    end
    for (int c = 0; c < 8; c++) begin
      prod[c][0] = $signed(gdat[c][GRAD_W-1:0])          * offs[0][c[2]];
      prod[c][1] = $signed(gdat[c][2*GRAD_W-1:GRAD_W])   * offs[1][c[1]];
      prod[c][2] = $signed(gdat[c][3*GRAD_W-1:2*GRAD_W]) * offs[2][c[0]];
    end
    for (int i = 0; i < 4; i++) begin
      wxy[i] = wgt[0][i/2] * wgt[1][i%2];
    end
  end

  logic                  v4_q;
  logic signed [PrW-1:0] prod4_q [8][3];
  logic [F:0]            wxy4_q  [4];
  logic [F:0]            wz4_q   [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      prod4_q <= prod;
      for (int i = 0; i < 4; i++) begin
        wxy4_q[i] <= wxy[i][2*F:F];
      end
      wz4_q[0] <= wgt[2][0];
      wz4_q[1] <= wgt[2][1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 4 -> 5: corner weight and dot product
  // --------------------------------------------------------------------------
  logic [2*F+1:0]         wful [8];
  logic signed [SumW-1:0] dsum [8];
  logic signed [SumW-1:0] dshf [8];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      wful[c] = wxy4_q[c/2] * wz4_q[c%2];
      dsum[c] = SumW'(prod4_q[c][0]) + SumW'(prod4_q[c][1]) + SumW'(prod4_q[c][2]);
      dshf[c] = dsum[c] >>> F;
    end
  end

  logic                 v5_q;
  logic [F:0]           w5_q [8];
  logic signed [DW-1:0] d5_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 8; c++) begin
        w5_q[c] <= wful[c][2*F:F];
        d5_q[c] <= DW'(dshf[c]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 5 -> 6: weighted terms
  // --------------------------------------------------------------------------
  logic signed [DW+F+1:0] tful [8];
  logic signed [DW+F+1:0] tshf [8];

  always_comb begin
    for (int c = 0; c < 8; c++) begin
      tful[c] = d5_q[c] * $signed({1'b0, w5_q[c]});
      tshf[c] = tful[c] >>> F;
    end
  end

  logic                 v6_q;
  logic signed [TW-1:0] t6_q [8];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      for (int c = 0; c < 8; c++) begin
        t6_q[c] <= TW'(tshf[c]);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stage 6 -> 7: half sums; stage 7 -> out: total and saturate
  // --------------------------------------------------------------------------
  logic signed [HW-1:0] half [2];

  always_comb begin
    for (int h = 0; h < 2; h++) begin
      half[h] = HW'(t6_q[4*h]) + HW'(t6_q[4*h+1]) + HW'(t6_q[4*h+2]) + HW'(t6_q[4*h+3]);
    end
  end

  logic                 v7_q;
  logic signed [HW-1:0] half7_q [2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else if (adv) begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      half7_q <= half;
    end
  end

  logic signed [AccW-1:0]    acc;
  logic signed [NOISE_W-1:0] noise_d;

  always_comb begin
    acc = AccW'(half7_q[0]) + AccW'(half7_q[1]);
    if (acc > SatHi) begin
      noise_d = NOISE_W'(SatHi);
    end else if (acc < SatLo) begin
      noise_d = NOISE_W'(SatLo);
    end else begin
      noise_d = NOISE_W'(acc);
    end
  end

  logic                      out_valid_q;
  logic signed [NOISE_W-1:0] noise_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      noise_q <= noise_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign noise_value_o = noise_q;

endmodule
